// File: hdl/wildcard_pattern_matcher_defines.svh
// Assertion macros for the wildcard pattern matcher.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef WILDCARD_PATTERN_MATCHER_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define WPM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wpm: assertion failed");
// Clocked check that also holds through reset.
`define WPM_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("wpm: assertion failed");
`else
`define WPM_ASSERT(name, prop)
`define WPM_ASSERT_ALWAYS(name, prop)
`endif

`endif

// File: hdl/wpm_pkg.sv
// Shared types and constants for the wildcard pattern matcher.
// No dependencies.
package wpm_pkg;

  localparam int unsigned MaxPatDefault = 64;

  localparam logic [7:0] CharAnyOne = 8'h3F;  // '?'
  localparam logic [7:0] CharAnyRun = 8'h2A;  // '*'

  typedef enum logic [1:0] {
    OpPatChar  = 2'd0,
    OpPatEnd   = 2'd1,
    OpTextChar = 2'd2,
    OpTextEnd  = 2'd3
  } wpm_op_e;

  typedef struct packed {
    wpm_op_e    op;
    logic [7:0] ch;
  } wpm_in_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } wpm_out_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic       load;     // pattern char accepted
    logic       fresh;    // that char starts a new pattern
    logic       step;     // text char accepted
    logic       restart;  // pattern end or text end accepted
    logic [7:0] ch;
  } wpm_cmd_t;

  // Handed from cell i to cell i+1.
  typedef struct packed {
    logic used;   // position holds a pattern char
    logic carry;  // star closure into the next position
    logic adv;    // match advances into the next position
  } wpm_link_t;

endpackage

// File: hdl/wpm_cell.sv
// One pattern position of the wildcard matcher: stored char, fill flag, active bit.
// Depends on wpm_pkg.
module wpm_cell #(
  parameter bit IsHead = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wpm_pkg::wpm_cmd_t cmd_i,
  input  wpm_pkg::wpm_link_t link_i,
  output wpm_pkg::wpm_link_t link_o,
  output logic              hit_o
);
  import wpm_pkg::*;

  logic [7:0] char_q, char_d;
  logic       used_q, used_d;
  logic       act_q, act_d;
  logic       used_eff, wr, is_star, is_eq, cur;

  always_comb begin
    used_eff = used_q & ~cmd_i.fresh;
    // first free position takes the char
    wr       = cmd_i.load & link_i.used & ~used_eff;
    is_star  = (char_q == CharAnyRun);
    is_eq    = (char_q == CharAnyOne) | (char_q == cmd_i.ch);
    cur      = act_q | link_i.carry;

    link_o.used  = used_eff;
    link_o.carry = cur & used_q & is_star;
    link_o.adv   = cur & used_q & ~is_star & is_eq;

    // this is the end-of-pattern position
    hit_o = cur & ~used_q & link_i.used;

    used_d = used_eff | wr;
    char_d = wr ? cmd_i.ch : char_q;

    if (cmd_i.restart) begin
      act_d = IsHead;
    end else if (cmd_i.step) begin
      act_d = (cur & used_q & is_star) | link_i.adv;
    end else begin
      act_d = act_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      act_q  <= IsHead;
    end else begin
      used_q <= used_d;
      act_q  <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

endmodule

// File: hdl/wildcard_pattern_matcher.sv
// Top level of the wildcard pattern matcher: command decode, chain of cells,
// end position and result register. Depends on wpm_pkg, wpm_cell and the defines header.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one transaction per
//   item: op selects pattern char, pattern end, text char or text end; ch is the byte.
//   Load pattern chars ('?' = any one byte, '*' = any run, empty too), close the
//   pattern with pattern end, then stream text bytes and finish with text end.
//   Only text end yields a result transaction on the output channel
//   (out_valid_o / out_stall_i / out_data_o): matched and overflow.
//   One item per cycle while in_stall_o is low. The result is registered and shows
//   up the cycle after the text end transaction is accepted.
//   The clock period is set by the star-closure ripple, which runs combinationally
//   through all MaxPat cells like a carry chain.
//   Patterns longer than MaxPat drop the extra chars, set overflow and never match.
//   Reset (rst_ni low, async) empties the pattern, activates only position zero
//   and clears the result valid flag.
//   While a result waits and the receiver stalls, in_stall_o is raised and no
//   new transaction is taken until the result leaves.
module wildcard_pattern_matcher #(
  parameter int unsigned MaxPat = wpm_pkg::MaxPatDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  wpm_pkg::wpm_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wpm_pkg::wpm_out_t out_data_o
);
  import wpm_pkg::*;

`include "wildcard_pattern_matcher_defines.svh"

  wpm_cmd_t  cmd;
  wpm_link_t link [MaxPat+1];
  logic [MaxPat:0]   hit_vec;
  logic [MaxPat-1:0] used_vec;

  logic     accept;
  logic     closed_q, closed_d;
  logic     overflow_q, overflow_d;
  logic     act_end_q, act_end_d;
  logic     cur_end, hit;
  logic     out_valid_q, out_valid_d;
  wpm_out_t out_data_q, out_data_d;

  // Result slot full and receiver stalling: hold the input side.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    cmd.load    = accept & (in_data_i.op == OpPatChar);
    cmd.fresh   = accept & (in_data_i.op == OpPatChar) & closed_q;
    cmd.step    = accept & (in_data_i.op == OpTextChar);
    cmd.restart = accept & ((in_data_i.op == OpPatEnd) | (in_data_i.op == OpTextEnd));
    cmd.ch      = in_data_i.ch;
  end

  // Position zero always sees a filled predecessor.
  assign link[0] = '{used: 1'b1, carry: 1'b0, adv: 1'b0};

  for (genvar gi = 0; gi < MaxPat; gi++) begin : g_cell
    wpm_cell #(
      .IsHead (gi == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .link_i (link[gi]),
      .link_o (link[gi+1]),
      .hit_o  (hit_vec[gi])
    );
    assign used_vec[gi] = link[gi+1].used;
  end

  // Position MaxPat: only an active bit, reached when every cell is filled.
  assign cur_end         = act_end_q | link[MaxPat].carry;
  assign hit_vec[MaxPat] = cur_end & link[MaxPat].used;
  assign hit             = |hit_vec;

  always_comb begin
    closed_d    = closed_q;
    overflow_d  = overflow_q;
    act_end_d   = act_end_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;

    if (cmd.load) begin
      closed_d   = 1'b0;
      // a fresh pattern always has room for its first char
      overflow_d = cmd.fresh ? 1'b0 : (overflow_q | link[MaxPat].used);
    end
    if (cmd.restart) begin
      act_end_d = 1'b0;
    end else if (cmd.step) begin
      act_end_d = link[MaxPat].adv;
    end

    if (accept) begin
      case (in_data_i.op)
        OpPatEnd: begin
          closed_d = 1'b1;
        end
        OpTextEnd: begin
          out_valid_d         = 1'b1;
          out_data_d.matched  = hit & ~overflow_q;
          out_data_d.overflow = overflow_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q    <= 1'b0;
      overflow_q  <= 1'b0;
      act_end_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      closed_q    <= closed_d;
      overflow_q  <= overflow_d;
      act_end_q   <= act_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Filled positions form a contiguous run from position zero.
  `WPM_ASSERT(a_used_thermo, !cmd.fresh |-> $onehot({1'b0, used_vec} + (MaxPat+1)'(1)))
  // Overflow only with every position filled.
  `WPM_ASSERT(a_ovf_full, overflow_q && !cmd.fresh |-> used_vec[MaxPat-1])
  // A text end transaction always lands in the result register.
  `WPM_ASSERT(a_text_end_result, accept && in_data_i.op == OpTextEnd |=> out_valid_q)
  // Never report a match for an overflowed pattern.
  `WPM_ASSERT_ALWAYS(a_no_match_on_ovf, out_valid_o |-> !(out_data_o.matched && out_data_o.overflow))

endmodule

// File: verif/wildcard_pattern_matcher_test.sv
// Self-checking testbench for wildcard_pattern_matcher: directed and random pattern/text
// sessions, a bit-accurate match tracker and random idling on both channels.
// Depends on wpm_pkg and the wildcard_pattern_matcher RTL.
module wildcard_pattern_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wpm_pkg::*;

  localparam int unsigned MaxPat = MaxPatDefault;
  localparam int unsigned RandomItems = 1800;
  // Worst case is roughly 2.5k items; this leaves ample margin.
  localparam longint unsigned CycleLimit = 1_000_000;

  // Tracks the pattern and the set of live pattern positions.
  // Each text end transaction queues one expected verdict.
  class match_tracker;
    logic [7:0]    pat_chars[MaxPat];
    int unsigned   pat_len;
    bit [MaxPat:0] live;
    bit            pat_ovf;
    bit            pat_closed;
    wpm_out_t      expected_verdicts[$];
    int unsigned   errors;

    function new();
      pat_len    = 0;
      live       = 1;
      pat_ovf    = 1'b0;
      pat_closed = 1'b0;
      errors     = 0;
    endfunction

    function void note_item(wpm_in_t item);
      bit [MaxPat:0] cur;
      bit [MaxPat:0] nxt;
      wpm_out_t      verdict;
      case (item.op)
        OpPatChar: begin
          // A char after a closed pattern begins a new one.
          if (pat_closed) begin
            pat_closed = 1'b0;
            pat_len    = 0;
            pat_ovf    = 1'b0;
          end
          if (pat_len < MaxPat) begin
            pat_chars[pat_len] = item.ch;
            pat_len++;
          end else begin
            pat_ovf = 1'b1;
          end
        end
        OpPatEnd: begin
          pat_closed = 1'b1;
          live       = 1;
        end
        default: begin
          // Star closure ripples upward, so a run of stars opens all of them.
          cur = live;
          for (int i = 0; i < pat_len; i++) begin
            if (cur[i] && pat_chars[i] == CharAnyRun) cur[i+1] = 1'b1;
          end
          if (item.op == OpTextChar) begin
            nxt = '0;
            for (int i = 0; i < pat_len; i++) begin
              if (cur[i]) begin
                if (pat_chars[i] == CharAnyRun) nxt[i] = 1'b1;
                else if (pat_chars[i] == CharAnyOne || pat_chars[i] == item.ch) nxt[i+1] = 1'b1;
              end
            end
            live = nxt;
          end else begin
            verdict.matched  = cur[pat_len] && !pat_ovf;
            verdict.overflow = pat_ovf;
            expected_verdicts.push_back(verdict);
            live = 1;
          end
        end
      endcase
    endfunction

    function void check_verdict(wpm_out_t got);
      wpm_out_t want;
      if (expected_verdicts.size() == 0) begin
        $error("result transaction with nothing expected: matched %0b overflow %0b",
               got.matched, got.overflow);
        errors++;
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.matched !== want.matched) begin
        $error("matched: expected %0b, actual %0b", want.matched, got.matched);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  wpm_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  wpm_out_t out_data_o;

  match_tracker tracker = new();

  int unsigned sent_items = 0;
  bit          tx_calm    = 1'b0;  // sender runs back to back while set

  wildcard_pattern_matcher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    longint unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Monitor: sample both channels at the rising edge. Inputs are driven at the
  // falling edge, so the values seen here are the settled pre-edge ones.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_stall_o === 1'b0) tracker.note_item(in_data_i);
      if (out_valid_o === 1'b1 && !out_stall_i) tracker.check_verdict(out_data_o);
    end
  end

  // Receiver pacing: mostly short stalls, a few long ones, and calm stretches
  // with no stall at all so the block also runs at full rate.
  initial begin : rx_pacing
    int stall_left;
    int calm_left;
    int r;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(negedge clk_i);
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 299) == 0) calm_left = $urandom_range(50, 300);
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (calm_left > 0) begin
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall_i <= 1'b0;
        end else begin
          stall_left = (r < 90) ? $urandom_range(1, 3) :
                       (r < 98) ? $urandom_range(4, 10) : $urandom_range(15, 40);
          out_stall_i <= 1'b1;
          stall_left--;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] alpha_char();
    return 8'h61 + 8'($urandom_range(0, 2));  // 'a'..'c' so literals actually hit
  endfunction

  function automatic logic [7:0] pat_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return CharAnyRun;
    if (r < 35) return CharAnyOne;
    if (r < 85) return alpha_char();
    return 8'($urandom_range(0, 255));
  endfunction

  // Text may carry '?' and '*' bytes too; they are plain bytes there.
  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return alpha_char();
    if (r < 75) return CharAnyOne;
    if (r < 80) return CharAnyRun;
    return 8'($urandom_range(0, 255));
  endfunction

  // One transaction: optional gap, then hold valid until it is taken. Called and
  // returns at a falling edge; valid stays high into the next call when no gap.
  task automatic send_item(wpm_op_e op, logic [7:0] ch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{op: op, ch: ch};
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sent_items++;
    @(negedge clk_i);
  endtask

  // Sender holds off until every verdict has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (tracker.expected_verdicts.size() != 0);
  endtask

  // A pattern followed by a few texts. Most texts are built from the pattern
  // so they match, some are mutated near-misses, the rest are random.
  // forced_len < 0 picks a random length.
  task automatic run_session(int forced_len);
    logic [7:0] pat[$];
    logic [7:0] txt[$];
    int         len;
    int         r;
    int         pos;
    if (forced_len >= 0) begin
      len = forced_len;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(0, 8);
      else if (r < 95) len = ($urandom_range(0, 3) == 0) ? MaxPat : $urandom_range(9, MaxPat);
      else len = $urandom_range(MaxPat + 1, MaxPat + 6);  // overflow
    end
    repeat (len) pat.push_back(pat_char());
    foreach (pat[k]) send_item(OpPatChar, pat[k]);
    // Occasionally leave the pattern open: texts then run on what is stored.
    if ($urandom_range(0, 19) != 0) send_item(OpPatEnd, 8'($urandom_range(0, 255)));

    repeat ($urandom_range(1, 4)) begin
      txt.delete();
      r = $urandom_range(0, 99);
      if (r < 70) begin
        foreach (pat[k]) begin
          if (pat[k] == CharAnyRun) repeat ($urandom_range(0, 3)) txt.push_back(text_char());
          else if (pat[k] == CharAnyOne) txt.push_back(8'($urandom_range(0, 255)));
          else txt.push_back(pat[k]);
        end
        if (r >= 50) begin
          // Near miss: change, drop or add one byte.
          pos = (txt.size() > 0) ? $urandom_range(0, txt.size() - 1) : 0;
          case ($urandom_range(0, 2))
            0:       if (txt.size() > 0) txt[pos] = text_char();
            1:       if (txt.size() > 0) txt.delete(pos);
            default: txt.insert(pos, text_char());
          endcase
        end
      end else begin
        repeat ($urandom_range(0, 10)) txt.push_back(text_char());
      end
      foreach (txt[k]) begin
        // Rarely a pattern char lands in the middle of a text.
        if ($urandom_range(0, 32) == 0) send_item(OpPatChar, pat_char());
        send_item(OpTextChar, txt[k]);
      end
      send_item(OpTextEnd, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int unsigned start_count;
    int          session;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty pattern: the empty text matches, a one-byte text does not.
    send_item(OpTextEnd, 8'hFF);
    send_item(OpTextChar, 8'h00);
    send_item(OpTextEnd, 8'h00);
    // A lone star matches the empty text.
    send_item(OpPatChar, CharAnyRun);
    send_item(OpPatEnd, 8'h00);
    send_item(OpTextEnd, 8'hFF);
    // Char after pattern end starts a new pattern "?"; text runs before any
    // pattern end, on what is stored so far.
    send_item(OpPatChar, CharAnyOne);
    send_item(OpTextChar, 8'hFF);
    send_item(OpTextEnd, 8'h55);
    // Pattern char in the middle of a text is appended, live set untouched.
    send_item(OpTextChar, CharAnyRun);
    send_item(OpPatChar, 8'hFF);
    send_item(OpTextChar, 8'hFF);
    send_item(OpTextEnd, 8'hAA);
    // Wildcard bytes in the text only match themselves.
    send_item(OpPatEnd, 8'hC3);
    send_item(OpPatChar, 8'h00);
    send_item(OpPatChar, CharAnyOne);
    send_item(OpPatEnd, 8'h7E);
    send_item(OpTextChar, 8'h00);
    send_item(OpTextChar, CharAnyRun);
    send_item(OpTextEnd, 8'h81);
    send_item(OpTextChar, CharAnyOne);
    send_item(OpTextChar, CharAnyOne);
    send_item(OpTextEnd, 8'h18);

    wait_drained();

    // Random sessions. The first two cover an overflowing pattern and a
    // pattern of exactly MaxPat chars.
    start_count = sent_items;
    session     = 0;
    while (sent_items - start_count < RandomItems) begin
      if ($urandom_range(0, 9) == 0) tx_calm = !tx_calm;
      if (session == 0) begin
        run_session(MaxPat + 2);
      end else if (session == 1) begin
        run_session(MaxPat);
      end else if ($urandom_range(0, 99) < 8) begin
        // Noise: arbitrary ops and bytes.
        repeat ($urandom_range(1, 6))
          send_item(wpm_op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        run_session(-1);
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
      session++;
    end

    wait_drained();
    repeat (4) @(posedge clk_i);

    if (tracker.expected_verdicts.size() != 0) begin
      $error("%0d expected results never arrived", tracker.expected_verdicts.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
